// File: rtl/tctd_pkg.sv
// Shared types, constants and helper functions of the trellis tile codeword decoder.
package tctd_pkg;

  localparam int unsigned MaxBits   = 8;
  localparam int unsigned TileRows  = 4 * MaxBits;
  localparam int unsigned RowAw     = $clog2(TileRows);

  localparam logic [0:0]  CmdWrite  = 1'b0;
  localparam logic [0:0]  CmdDecode = 1'b1;

  localparam logic [0:0]  RegBits   = 1'b0;
  localparam logic [0:0]  RegCbSel  = 1'b1;

  localparam logic [0:0]  Cb3Inst   = 1'b0;

  localparam logic [31:0] McgMul    = 32'hCBAC1FED;
  localparam logic [31:0] InstMul   = 32'd89226354;
  localparam logic [31:0] InstAdd   = 32'd64248484;
  localparam logic [31:0] HalfMask  = 32'h8fff8fff;
  localparam logic [31:0] HalfXor   = 32'h3b603b60;

  typedef struct packed {
    logic [0:0]  cmd;
    logic [6:0]  word_index;
    logic [15:0] word_data;
    logic [7:0]  weight_index;
  } in_t;

  typedef struct packed {
    logic [7:0]  row_major_position;
    logic [15:0] weight_half;
  } res_t;

  // Two fp16 halves on their way into the adder, tagged with the tile position.
  typedef struct packed {
    logic        valid;
    logic [7:0]  pos;
    logic [15:0] lo;
    logic [15:0] hi;
  } add_in_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } add_out_t;

  // Row offsets of the eight weights that share one lane.
  function automatic logic [3:0] row_offset(input logic [2:0] sub);
    logic [3:0] r;
    begin
      unique case (sub[1:0])
        2'd0:    r = 4'd0;
        2'd1:    r = 4'd1;
        2'd2:    r = 4'd8;
        default: r = 4'd9;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] tile_position(input logic [7:0] t);
    logic [4:0] lane;
    logic [3:0] r;
    logic [3:0] c;
    begin
      lane = t[7:3];
      r    = {1'b0, lane[1:0], 1'b0} + row_offset(t[2:0]);
      c    = {1'b0, lane[4:2]} + (t[2] ? 4'd8 : 4'd0);
      return {r, c};
    end
  endfunction

endpackage

// File: rtl/trellis_tile_codeword_decoder.sv
// Top level of the trellis tile codeword decoder: command intake, window fetch, codebook.
//
// The block keeps one quantized tile of up to 128 halfwords and turns trellis
// codewords into fp16 weights. A command beat is taken at each rising edge at
// which start is high; busy stays low, so one beat can enter every cycle.
// A write beat (cmd low) stores word_data at word_index and gives no result.
// A decode beat (cmd high) gives one result beat: the strobe result_strobe_o
// is high for exactly one cycle with the weight's row-major position and its
// fp16 value. Results leave in the order the decodes came in.
// The path is: window address and tile read, window extraction and codebook
// multiply, mask and xor, fp16 align and add, normalize and round. One decode
// finishes per cycle; the two read ports of the tile memory fetch both words
// a window can straddle in one access, so no decode waits on another.
// A write lands in the memory at its own edge, so a decode in the very next
// cycle already reads the new halfword and no forwarding is needed.
// The configuration port writes bits_per_weight (index 0) and codebook_select
// (index 1) at any edge with cfg_we_i high; the user must use it only while
// idle; the block does not enforce this. Reset clears the pipeline valid bits
// and sets bits_per_weight to 4 and the MCG codebook; tile contents are undefined
// until written. The receiver has no way to stall, so nothing backs up.
module trellis_tile_codeword_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tctd_pkg::in_t    in_i,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [3:0]       cfg_data_i,
  output logic             result_strobe_o,
  output tctd_pkg::res_t   res_o
);

  // Configuration registers.
  logic [3:0] bits_q;
  logic       cbsel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q  <= 4'd4;
      cbsel_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tctd_pkg::RegBits:  bits_q  <= cfg_data_i;
        tctd_pkg::RegCbSel: cbsel_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept, dec_accept, wr_accept;
  assign accept     = start && !busy;
  assign dec_accept = accept && (in_i.cmd == tctd_pkg::CmdDecode);
  assign wr_accept  = accept && (in_i.cmd == tctd_pkg::CmdWrite);

  // Window address. The stream bit of the window start, taken modulo the tile
  // length, is (t+1)*bits - 16, wrapped up by one tile when it goes negative.
  logic [3:0]  eff_bits;
  logic [12:0] prod;
  logic [12:0] start_bit;
  logic [5:0]  w0, w1, w0_next;
  logic [4:0]  off;
  logic        span;
  logic [4:0]  shift_d;
  logic [6:0]  words;

  always_comb begin
    if (bits_q == 4'd0) begin
      eff_bits = 4'd1;
    end else if (bits_q > 4'(tctd_pkg::MaxBits)) begin
      eff_bits = 4'(tctd_pkg::MaxBits);
    end else begin
      eff_bits = bits_q;
    end
    prod      = 13'({1'b0, in_i.weight_index} + 9'd1) * 13'(eff_bits);
    start_bit = (prod < 13'd16) ? (prod + {1'b0, eff_bits, 8'd0} - 13'd16)
                                : (prod - 13'd16);
    w0        = start_bit[10:5];
    off       = start_bit[4:0];
    span      = off > 5'd16;
    words     = {eff_bits, 3'b000};
    w0_next   = ({1'b0, w0} + 7'd1 == words) ? 6'd0 : (w0 + 6'd1);
    w1        = span ? w0_next : w0;
    shift_d   = span ? 5'(6'd48 - {1'b0, off}) : 5'(5'd16 - off);
  end

  logic [63:0] rd_a, rd_b;

  tctd_tile_mem u_mem (
    .clk_i      (clk_i),
    .we_i       (wr_accept),
    .wr_idx_i   (in_i.word_index),
    .wr_data_i  (in_i.word_data),
    .rd_row_a_i (w0[5:1]),
    .rd_row_b_i (w1[5:1]),
    .rd_a_o     (rd_a),
    .rd_b_o     (rd_b)
  );

  // Stage 1: side data that travels with the memory read.
  logic       v1_q;
  logic [4:0] shift_q;
  logic       w0_odd_q, w1_odd_q, cb1_q;
  logic [7:0] pos1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= dec_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q  <= shift_d;
    w0_odd_q <= w0[0];
    w1_odd_q <= w1[0];
    cb1_q    <= cbsel_q;
    pos1_q   <= tctd_pkg::tile_position(in_i.weight_index);
  end

  // Window extraction and the codebook multiply.
  logic [63:0] joined;
  logic [63:0] shifted;
  logic [15:0] window;
  logic [31:0] mul_d;

  always_comb begin
    joined  = {(w0_odd_q ? rd_a[63:32] : rd_a[31:0]),
               (w1_odd_q ? rd_b[63:32] : rd_b[31:0])};
    shifted = joined >> shift_q;
    window  = shifted[15:0];
    mul_d   = {16'd0, window} * ((cb1_q == tctd_pkg::Cb3Inst) ? tctd_pkg::InstMul
                                                            : tctd_pkg::McgMul);
  end

  logic        v2_q, cb2_q;
  logic [31:0] mul_q;
  logic [7:0]  pos2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q  <= mul_d;
    cb2_q  <= cb1_q;
    pos2_q <= pos1_q;
  end

  // Stage 3: offset for 3INST, then mask and xor into two fp16 halves.
  logic [31:0]       scr;
  tctd_pkg::add_in_t add_d, add_q;

  always_comb begin
    scr = (cb2_q == tctd_pkg::Cb3Inst) ? (mul_q + tctd_pkg::InstAdd) : mul_q;
    scr = (scr & tctd_pkg::HalfMask) ^ tctd_pkg::HalfXor;
    add_d.valid = v2_q;
    add_d.pos   = pos2_q;
    add_d.lo    = scr[15:0];
    add_d.hi    = scr[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_q <= '0;
    end else begin
      add_q <= add_d;
    end
  end

  tctd_pkg::add_out_t add_out;

  tctd_half_add u_add (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (add_q),
    .out_o  (add_out)
  );

  assign result_strobe_o = add_out.valid;
  assign res_o           = add_out.res;

  // Every decode beat yields its result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_accept |-> ##5 result_strobe_o)
    else $error("decode beat without result beat");

  // The halves are always normal and small, so a result is zero or normal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && (res_o.weight_half[14:0] != 15'd0)) |->
      ((res_o.weight_half[14:10] != 5'd0) && (res_o.weight_half[14:10] != 5'd31)))
    else $error("decoded weight is subnormal or not finite");

  // Both fetched rows lie inside the tile that the current width defines.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_accept |-> (({1'b0, w0[5:1]} < {eff_bits, 2'b00}) &&
                    ({1'b0, w1[5:1]} < {eff_bits, 2'b00})))
    else $error("window row outside the tile");

endmodule

// File: rtl/tctd_tile_mem.sv
// Tile store: 32 rows of four halfwords, halfword writes, two registered read ports.
module tctd_tile_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [6:0]                wr_idx_i,
  input  logic [15:0]               wr_data_i,
  input  logic [tctd_pkg::RowAw-1:0] rd_row_a_i,
  input  logic [tctd_pkg::RowAw-1:0] rd_row_b_i,
  output logic [63:0]               rd_a_o,
  output logic [63:0]               rd_b_o
);

  logic [63:0] mem_q [tctd_pkg::TileRows];

  // A row holds an even 32-bit word in its low half and the odd word above it;
  // inside a word the even halfword sits low.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_idx_i[6:2]][{wr_idx_i[1:0], 4'b0000} +: 16] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_o <= mem_q[rd_row_a_i];
    rd_b_o <= mem_q[rd_row_b_i];
  end

endmodule

// File: rtl/tctd_half_add.sv
// Two-stage fp16 adder for the normal halves that the codebook produces.
module tctd_half_add (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tctd_pkg::add_in_t   in_i,
  output tctd_pkg::add_out_t  out_o
);

  typedef struct packed {
    logic        valid;
    logic [7:0]  pos;
    logic        sign;
    logic [4:0]  exp;
    logic [14:0] sum;
  } align_t;

  // Stage A: order by magnitude, align and add. Both halves are normal with
  // exponents 12 to 15, so the alignment shift is at most three and exact.
  logic        swap;
  logic [15:0] big, lesser;
  logic [4:0]  dexp;
  logic [13:0] ma, mb;
  align_t      a_d, a_q;

  always_comb begin
    swap   = in_i.hi[14:0] > in_i.lo[14:0];
    big    = swap ? in_i.hi : in_i.lo;
    lesser = swap ? in_i.lo : in_i.hi;
    dexp   = big[14:10] - lesser[14:10];
    ma     = {(|big[14:10]), big[9:0], 3'b000};
    mb     = {(|lesser[14:10]), lesser[9:0], 3'b000} >> dexp;
    a_d.valid = in_i.valid;
    a_d.pos   = in_i.pos;
    a_d.sign  = big[15];
    a_d.exp   = big[14:10];
    a_d.sum   = (in_i.lo[15] ^ in_i.hi[15]) ? ({1'b0, ma} - {1'b0, mb})
                                            : ({1'b0, ma} + {1'b0, mb});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else begin
      a_q <= a_d;
    end
  end

  // Stage B: find the leading one, normalize and round to nearest even.
  logic [3:0]  lead;
  logic [14:0] norm;
  logic [5:0]  rexp;
  logic        rnd;
  logic [15:0] half_d;
  tctd_pkg::add_out_t out_d, out_q;

  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (a_q.sum[i]) lead = 4'(i);
    end
    norm = a_q.sum << (4'd14 - lead);
    rexp = {1'b0, a_q.exp} + {2'b00, lead} - 6'd13;
    rnd  = norm[3] & ((|norm[2:0]) | norm[4]);
    if (a_q.sum == 15'd0) begin
      half_d = 16'h0000;
    end else begin
      half_d = {a_q.sign, ({rexp[4:0], norm[13:4]} + {14'd0, rnd})};
    end
    out_d.valid                  = a_q.valid;
    out_d.res.row_major_position = a_q.pos;
    out_d.res.weight_half        = half_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// File: bench/trellis_tile_codeword_decoder_tb.sv
// Self-checking testbench of the trellis tile codeword decoder: loads tiles, decodes weights.
module trellis_tile_codeword_decoder_tb;

  // The scoreboard holds the decoded weights that are still due, oldest first.
  class weight_scoreboard;
    tctd_pkg::res_t due_q[$];
    int   n_bad;

    function void note_decode(tctd_pkg::res_t r);
      due_q.push_back(r);
    endfunction

    function void check_weight(tctd_pkg::res_t got);
      tctd_pkg::res_t want;
      if (due_q.size() == 0) begin
        $error("result beat with no decode pending: pos=%0h half=%0h",
               got.row_major_position, got.weight_half);
        n_bad++;
        return;
      end
      want = due_q.pop_front();
      if (got.row_major_position !== want.row_major_position) begin
        $error("row_major_position: expected %0h, actual %0h",
               want.row_major_position, got.row_major_position);
        n_bad++;
      end
      if (got.weight_half !== want.weight_half) begin
        $error("weight_half: expected %0h, actual %0h", want.weight_half, got.weight_half);
        n_bad++;
      end
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  tctd_pkg::in_t  in_i = '0;
  logic           cfg_we_i = 1'b0;
  logic [0:0]     cfg_index_i = tctd_pkg::RegBits;
  logic [3:0]     cfg_data_i = '0;
  logic           result_strobe_o;
  tctd_pkg::res_t res_o;

  trellis_tile_codeword_decoder uut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .result_strobe_o, .res_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  weight_scoreboard sb = new();

  // Mirror of the block: the tile halfwords and both configuration registers.
  logic [15:0] tile_mirror [128];
  logic [3:0]  bits_reg;
  logic        cb_reg;

  // Result beats can never be held off, so every strobe is checked at once.
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) sb.check_weight(res_o);
  end

  function automatic logic [31:0] tile_word32(int unsigned idx);
    return {tile_mirror[2 * idx + 1], tile_mirror[2 * idx]};
  endfunction

  // Exact value of a finite fp16 pattern in units of 2^-24.
  function automatic longint half_units(logic [15:0] h);
    longint mag;
    if (h[14:10] == 0) mag = h[9:0];
    else mag = longint'({1'b1, h[9:0]}) << (h[14:10] - 1);
    return h[15] ? -mag : mag;
  endfunction

  // Round an exact value in 2^-24 units to fp16, nearest even.
  function automatic logic [15:0] units_half(longint s, bit neg_zero);
    logic [15:0] sgn;
    longint unsigned a, m, rem, hlf;
    int p, k, enc;
    if (s == 0) return neg_zero ? 16'h8000 : 16'h0000;
    sgn = (s < 0) ? 16'h8000 : 16'h0000;
    a = (s < 0) ? -s : s;
    if (a < 2048) return sgn | a[15:0];
    p = 0;
    while (p < 63 && (a >> (p + 1)) != 0) p++;
    k = p - 10;
    m = a >> k;
    rem = a & ((64'd1 << k) - 1);
    hlf = 64'd1 << (k - 1);
    if (rem > hlf || (rem == hlf && m[0])) m++;
    if (k + 2 + (m >> 11) > 31) return sgn | 16'h7c00;
    enc = (k << 10) + int'(m);
    if (enc >= 'h7c00) return sgn | 16'h7c00;
    return sgn | enc[15:0];
  endfunction

  // Expected result of decoding weight t under the current settings.
  function automatic tctd_pkg::res_t predict_weight(logic [7:0] t);
    int unsigned nb, words, st, w0, w1, sh, lane, sub, r, c;
    logic [63:0] joined;
    logic [31:0] x;
    tctd_pkg::res_t o;
    nb = (bits_reg < 1) ? 1 : (bits_reg > tctd_pkg::MaxBits) ? tctd_pkg::MaxBits : bits_reg;
    words = nb * 8;
    st = t * nb + nb + 256 * nb - 16;
    w0 = st / 32;
    w1 = (st + 15) / 32;
    sh = (w1 + 1) * 32 - st - 16;
    joined = {tile_word32(w0 % words), tile_word32(w1 % words)};
    x = 32'(joined >> sh) & 32'hffff;
    if (cb_reg == tctd_pkg::Cb3Inst) x = x * tctd_pkg::InstMul + tctd_pkg::InstAdd;
    else x = x * tctd_pkg::McgMul;
    x = (x & tctd_pkg::HalfMask) ^ tctd_pkg::HalfXor;
    o.weight_half = units_half(half_units(x[15:0]) + half_units(x[31:16]),
                               x[15] && x[31]);
    lane = t[7:3];
    sub = t[2:0];
    r = (lane % 4) * 2 + ((sub % 4) == 0 ? 0 : (sub % 4) == 1 ? 1 : (sub % 4) == 2 ? 8 : 9);
    c = lane / 4 + (sub < 4 ? 0 : 8);
    o.row_major_position = 8'(r * 16 + c);
    return o;
  endfunction

  int gap_left = 0;

  // Present one command beat and hold it until accepted; bursts and gaps are random.
  task automatic send_beat(tctd_pkg::in_t beat);
    if (gap_left == 0 && $urandom_range(0, 9) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      gap_left = $urandom_range(1, 30);
    end
    start <= 1'b1;
    in_i  <= beat;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (gap_left > 0) gap_left--;
    // The beat was taken at this edge: update the mirror and the expectations.
    if (beat.cmd == tctd_pkg::CmdWrite) begin
      tile_mirror[beat.word_index] = beat.word_data;
    end else begin
      sb.note_decode(predict_weight(beat.weight_index));
    end
  endtask

  task automatic load_halfword(int unsigned idx, logic [15:0] data);
    tctd_pkg::in_t b;
    b = '0;
    b.cmd = tctd_pkg::CmdWrite;
    b.word_index = idx[6:0];
    b.word_data = data;
    b.weight_index = 8'($urandom);
    send_beat(b);
  endtask

  task automatic decode_weight(logic [7:0] t);
    tctd_pkg::in_t b;
    b = '0;
    b.cmd = tctd_pkg::CmdDecode;
    b.weight_index = t;
    b.word_index = 7'($urandom);
    b.word_data = 16'($urandom);
    send_beat(b);
  endtask

  // Drain the pipeline, then write one register while idle.
  task automatic write_reg(logic [0:0] idx, logic [3:0] val);
    int unsigned guard;
    start <= 1'b0;
    guard = 0;
    while (sb.due_q.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tctd_pkg::RegBits) bits_reg = val;
    else cb_reg = val[0];
  endtask

  // Write a whole tile for the current size so every decode reads written data.
  task automatic fill_tile(int unsigned nb, int mode);
    for (int unsigned i = 0; i < 16 * nb; i++) begin
      load_halfword(i, mode == 0 ? 16'h0000 : mode == 1 ? 16'hffff : 16'($urandom));
    end
  endtask

  initial begin
    int unsigned nb, n, dec;
    logic [0:0] cb_pick;
    for (int i = 0; i < 128; i++) begin
      tile_mirror[i] = '0;
    end
    bits_reg = 4;
    cb_reg = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset settings: all-zero and all-one tiles, extreme indices.
    fill_tile(4, 0);
    decode_weight(8'd0);
    decode_weight(8'd255);
    fill_tile(4, 1);
    decode_weight(8'd0);
    decode_weight(8'd255);
    decode_weight(8'd127);
    // A write past the current tile is stored but not read at this size.
    load_halfword(127, 16'hffff);
    load_halfword(64, 16'h0000);
    decode_weight(8'd128);
    write_reg(tctd_pkg::RegCbSel, {3'b000, tctd_pkg::Cb3Inst});
    decode_weight(8'd1);
    decode_weight(8'd254);
    // Out-of-range sizes act as one and as the maximum.
    write_reg(tctd_pkg::RegBits, 4'd0);
    fill_tile(1, 2);
    decode_weight(8'd0);
    decode_weight(8'd255);
    write_reg(tctd_pkg::RegBits, 4'd15);
    fill_tile(tctd_pkg::MaxBits, 2);
    decode_weight(8'd0);
    decode_weight(8'd255);

    // Random phases: each picks a size and codebook, loads a fresh tile, then
    // mixes decodes with rewrites of random halfwords anywhere in the store.
    n = 0;
    while (n < 420) begin
      nb = $urandom_range(1, 8);
      cb_pick = 1'($urandom);
      write_reg(tctd_pkg::RegBits,
                (n % 5 == 0) ? 4'($urandom_range(0, 15)) : 4'(nb));
      write_reg(tctd_pkg::RegCbSel, {3'b000, cb_pick});
      nb = (bits_reg < 1) ? 1 : (bits_reg > tctd_pkg::MaxBits) ? tctd_pkg::MaxBits : bits_reg;
      fill_tile(nb, $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : 2);
      n += 16 * nb;
      dec = $urandom_range(20, 80);
      for (int unsigned j = 0; j < dec; j++) begin
        if ($urandom_range(0, 5) == 0)
          load_halfword($urandom_range(0, 127), 16'($urandom));
        else
          decode_weight(8'($urandom));
        n++;
      end
    end

    start <= 1'b0;
    n = 0;
    while (sb.due_q.size() != 0 && n < 1000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.n_bad == 0 && sb.due_q.size() == 0) $display("PASS trellis_tile_codeword_decoder");
    else $display("FAIL trellis_tile_codeword_decoder");
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAIL trellis_tile_codeword_decoder");
    $finish;
  end

endmodule

// File: trellis_tile_codeword_decoder.f
rtl/tctd_pkg.sv
rtl/tctd_tile_mem.sv
rtl/tctd_half_add.sv
rtl/trellis_tile_codeword_decoder.sv
bench/trellis_tile_codeword_decoder_tb.sv
